@@ hw/rtl/pia_pkg.sv @@
// Shared opcodes, register addresses, control bit positions and side structs
// for the parallel interface adapter. No dependencies.
`default_nettype none
package pia_pkg;

    localparam logic [2:0] OP_READ  = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_PINSA = 3'd2;
    localparam logic [2:0] OP_PINSB = 3'd3;
    localparam logic [2:0] OP_CA1   = 3'd4;
    localparam logic [2:0] OP_CA2   = 3'd5;
    localparam logic [2:0] OP_CB1   = 3'd6;
    localparam logic [2:0] OP_CB2   = 3'd7;

    localparam logic [1:0] ADDR_PORTA = 2'd0;
    localparam logic [1:0] ADDR_CTLA  = 2'd1;
    localparam logic [1:0] ADDR_PORTB = 2'd2;
    localparam logic [1:0] ADDR_CTLB  = 2'd3;

    localparam int CR_IRQ1  = 7;
    localparam int CR_IRQ2  = 6;
    localparam int CR_L2OUT = 5;
    localparam int CR_L2MAN = 4;
    localparam int CR_L2LVL = 3;
    localparam int CR_DDR   = 2;
    localparam int CR_L1NEG = 1;
    localparam int CR_L1EN  = 0;

    localparam logic [7:0] PINS_RESET = 8'hFF;

    typedef struct packed {
        logic       ctl_wr;
        logic [7:0] data;
        logic       flag_clr;
        logic       strobe;
        logic       l1_evt;
        logic       l2_evt;
        logic       old_lvl;
        logic       new_lvl;
    } t_side_evt;

    typedef struct packed {
        logic [7:0] cr;
        logic       drive;
        logic       pulsed;
        logic       irq;
    } t_side_res;

endpackage
`default_nettype wire

@@ hw/rtl/pia_side.sv @@
// Next control register, line 2 drive level, line 2 strobe flag and IRQ level for one side.
// Depends on pia_pkg.
`default_nettype none
module pia_side
    import pia_pkg::*;
(
    input  wire logic [7:0] i_cr,
    input  wire logic       i_drive,
    input  wire t_side_evt  i_evt,
    output t_side_res       o_res
);

    logic [7:0] cr;
    logic       drv;
    logic       pulsed;
    logic       edge1;
    logic       edge2;

    always_comb begin
        cr     = i_cr;
        drv    = i_drive;
        pulsed = 1'b0;
        if (i_evt.ctl_wr) begin
            cr = {cr[7:6], i_evt.data[5:0]};
            if (cr[CR_L2OUT] && cr[CR_L2MAN]) begin
                drv = cr[CR_L2LVL];
            end
        end
        if (i_evt.flag_clr) begin
            cr[CR_IRQ1] = 1'b0;
            cr[CR_IRQ2] = 1'b0;
        end
        if (i_evt.strobe && cr[CR_L2OUT] && !cr[CR_L2MAN]) begin
            drv    = cr[CR_L2LVL];
            pulsed = 1'b1;
        end
        edge1 = cr[CR_L1NEG] ? (i_evt.old_lvl && !i_evt.new_lvl)
                             : (!i_evt.old_lvl && i_evt.new_lvl);
        if (i_evt.l1_evt && edge1) begin
            cr[CR_IRQ1] = 1'b1;
            if (cr[CR_L2OUT] && !cr[CR_L2MAN] && !cr[CR_L2LVL]) begin
                drv = 1'b1;
            end
        end
        edge2 = cr[CR_L2MAN] ? (i_evt.old_lvl && !i_evt.new_lvl)
                             : (!i_evt.old_lvl && i_evt.new_lvl);
        if (i_evt.l2_evt && !cr[CR_L2OUT] && edge2) begin
            cr[CR_IRQ2] = 1'b1;
        end
        o_res.cr     = cr;
        o_res.drive  = drv;
        o_res.pulsed = pulsed;
        o_res.irq    = (cr[CR_IRQ1] && cr[CR_L1EN])
                    || (cr[CR_IRQ2] && !cr[CR_L2OUT] && cr[CR_L2LVL]);
    end

endmodule
`default_nettype wire

@@ hw/rtl/peripheral_interface_adapter_core.sv @@
// Top level of the parallel interface adapter: input register, item decode,
// adapter state, and result register. Depends on pia_pkg and pia_side.
//
//   Channel | Handshake                 | Payload
//   in      | i_in_valid / o_in_ready   | i_opcode, i_reg_addr, i_data_byte, i_line_level
//   out     | o_out_valid / i_out_ready | o_read_data, o_port_*_drive, o_c*2_*, o_irq_*
//
// An item is registered at the input and processed once the output register is free
// or being drained, when its result is written to the output register; one item is
// accepted every cycle while the consumer does not stall. The output register
// and input register hold while the consumer stalls. Reset is synchronous and
// clears all adapter state; pins reset to all ones.
`default_nettype none
module peripheral_interface_adapter_core
    import pia_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [2:0] i_opcode,
    input  wire logic [1:0] i_reg_addr,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_line_level,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_read_data,
    output logic [7:0]      o_port_a_drive,
    output logic [7:0]      o_port_b_drive,
    output logic            o_ca2_level,
    output logic            o_cb2_level,
    output logic            o_ca2_pulsed,
    output logic            o_cb2_pulsed,
    output logic            o_irq_a,
    output logic            o_irq_b
);

    logic       r_in_vld;
    logic [2:0] r_op;
    logic [1:0] r_addr;
    logic [7:0] r_data;
    logic       r_lvl;

    logic [7:0] r_ctl_a, r_ctl_b, r_dir_a, r_dir_b;
    logic [7:0] r_out_a, r_out_b, r_pins_a, r_pins_b;
    logic [3:0] r_lines;
    logic       r_drv_a, r_drv_b;

    logic       r_out_vld;
    logic [7:0] r_rd;
    logic       r_ca2_pulsed, r_cb2_pulsed, r_irq_a, r_irq_b;

    logic       w_adv;
    t_side_evt  evt_a, evt_b;
    t_side_res  res_a, res_b;
    logic [7:0] n_rd;
    logic [7:0] n_dir_a, n_dir_b, n_out_a, n_out_b;
    logic [7:0] n_pins_a, n_pins_b;
    logic [3:0] n_lines;
    logic       old_lvl;

    assign w_adv       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || w_adv;
    assign old_lvl     = r_lines[r_op[1:0]];

    always_comb begin
        evt_a    = '0;
        evt_b    = '0;
        evt_a.data    = r_data;
        evt_b.data    = r_data;
        evt_a.old_lvl = old_lvl;
        evt_b.old_lvl = old_lvl;
        evt_a.new_lvl = r_lvl;
        evt_b.new_lvl = r_lvl;
        n_rd     = '0;
        n_dir_a  = r_dir_a;
        n_dir_b  = r_dir_b;
        n_out_a  = r_out_a;
        n_out_b  = r_out_b;
        n_pins_a = r_pins_a;
        n_pins_b = r_pins_b;
        n_lines  = r_lines;
        unique case (r_op)
            OP_READ: begin
                unique case (r_addr)
                    ADDR_PORTA: begin
                        if (r_ctl_a[CR_DDR]) begin
                            n_rd           = r_pins_a;
                            evt_a.flag_clr = 1'b1;
                            evt_a.strobe   = 1'b1;
                        end else begin
                            n_rd = r_dir_a;
                        end
                    end
                    ADDR_CTLA: begin
                        n_rd = r_ctl_a;
                        if (r_ctl_a[CR_L2OUT]) begin
                            n_rd[CR_IRQ2] = 1'b0;
                        end
                    end
                    ADDR_PORTB: begin
                        if (r_ctl_b[CR_DDR]) begin
                            n_rd           = (r_out_b & r_dir_b) | (r_pins_b & ~r_dir_b);
                            evt_b.flag_clr = 1'b1;
                        end else begin
                            n_rd = r_dir_b;
                        end
                    end
                    default: begin
                        n_rd = r_ctl_b;
                        if (r_ctl_b[CR_L2OUT]) begin
                            n_rd[CR_IRQ2] = 1'b0;
                        end
                    end
                endcase
            end
            OP_WRITE: begin
                unique case (r_addr)
                    ADDR_PORTA: begin
                        if (r_ctl_a[CR_DDR]) begin
                            n_out_a = r_data;
                        end else begin
                            n_dir_a = r_data;
                        end
                    end
                    ADDR_CTLA: evt_a.ctl_wr = 1'b1;
                    ADDR_PORTB: begin
                        if (r_ctl_b[CR_DDR]) begin
                            n_out_b      = r_data;
                            evt_b.strobe = 1'b1;
                        end else begin
                            n_dir_b = r_data;
                        end
                    end
                    default: evt_b.ctl_wr = 1'b1;
                endcase
            end
            OP_PINSA: n_pins_a = r_data;
            OP_PINSB: n_pins_b = r_data;
            default: begin
                n_lines[r_op[1:0]] = r_lvl;
                unique case (r_op)
                    OP_CA1:  evt_a.l1_evt = 1'b1;
                    OP_CA2:  evt_a.l2_evt = 1'b1;
                    OP_CB1:  evt_b.l1_evt = 1'b1;
                    default: evt_b.l2_evt = 1'b1;
                endcase
            end
        endcase
    end

    pia_side u_side_a (
        .i_cr    (r_ctl_a),
        .i_drive (r_drv_a),
        .i_evt   (evt_a),
        .o_res   (res_a)
    );

    pia_side u_side_b (
        .i_cr    (r_ctl_b),
        .i_drive (r_drv_b),
        .i_evt   (evt_b),
        .o_res   (res_b)
    );

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op   <= i_opcode;
            r_addr <= i_reg_addr;
            r_data <= i_data_byte;
            r_lvl  <= i_line_level;
        end
        if (w_adv) begin
            r_rd         <= n_rd;
            r_ca2_pulsed <= res_a.pulsed;
            r_cb2_pulsed <= res_b.pulsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_ctl_a   <= '0;
            r_ctl_b   <= '0;
            r_dir_a   <= '0;
            r_dir_b   <= '0;
            r_out_a   <= '0;
            r_out_b   <= '0;
            r_pins_a  <= PINS_RESET;
            r_pins_b  <= PINS_RESET;
            r_lines   <= '0;
            r_drv_a   <= 1'b0;
            r_drv_b   <= 1'b0;
            r_irq_a   <= 1'b0;
            r_irq_b   <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
                r_ctl_a   <= res_a.cr;
                r_ctl_b   <= res_b.cr;
                r_dir_a   <= n_dir_a;
                r_dir_b   <= n_dir_b;
                r_out_a   <= n_out_a;
                r_out_b   <= n_out_b;
                r_pins_a  <= n_pins_a;
                r_pins_b  <= n_pins_b;
                r_lines   <= n_lines;
                r_drv_a   <= res_a.drive;
                r_drv_b   <= res_b.drive;
                r_irq_a   <= res_a.irq;
                r_irq_b   <= res_b.irq;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_read_data    = r_rd;
    assign o_port_a_drive = r_out_a & r_dir_a;
    assign o_port_b_drive = r_out_b & r_dir_b;
    assign o_ca2_level    = r_drv_a;
    assign o_cb2_level    = r_drv_b;
    assign o_ca2_pulsed   = r_ca2_pulsed;
    assign o_cb2_pulsed   = r_cb2_pulsed;
    assign o_irq_a        = r_irq_a;
    assign o_irq_b        = r_irq_b;

    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_ca2_pulsed && r_cb2_pulsed))
        else $error("both strobes reported for one item");

    a_adv_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_vld)
        else $error("processed item did not reach the result register");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !w_adv |=> r_in_vld && $stable(r_op) && $stable(r_data))
        else $error("pending item lost from the input register");

    a_irq_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_irq_a == ((r_ctl_a[CR_IRQ1] && r_ctl_a[CR_L1EN])
                 || (r_ctl_a[CR_IRQ2] && !r_ctl_a[CR_L2OUT] && r_ctl_a[CR_L2LVL])))
        else $error("IRQ A level disagrees with control A");

endmodule
`default_nettype wire

@@ test/tb_peripheral_interface_adapter_core.sv @@
// Self-checking testbench for peripheral_interface_adapter_core: directed rows, then
// random bus accesses and pin/line events, each result checked against a local predictor
// or the typed result of its row. Depends on pia_pkg and the adapter RTL only.
`timescale 1ns / 1ps

module tb_peripheral_interface_adapter_core;
    import pia_pkg::*;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] port_a_drive;
        logic [7:0] port_b_drive;
        logic       ca2_level;
        logic       cb2_level;
        logic       ca2_pulsed;
        logic       cb2_pulsed;
        logic       irq_a;
        logic       irq_b;
    } t_adapter_out;

    typedef struct packed {
        logic [2:0]   op;
        logic [1:0]   addr;
        logic [7:0]   data;
        logic         lvl;
        logic         typed;
        t_adapter_out res;
    } t_stim_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [2:0] i_opcode;
    logic [1:0] i_reg_addr;
    logic [7:0] i_data_byte;
    logic       i_line_level;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_read_data;
    logic [7:0] o_port_a_drive;
    logic [7:0] o_port_b_drive;
    logic       o_ca2_level;
    logic       o_cb2_level;
    logic       o_ca2_pulsed;
    logic       o_cb2_pulsed;
    logic       o_irq_a;
    logic       o_irq_b;

    logic [7:0] ctl_a, ctl_b, ddr_a, ddr_b, ora, orb, pin_a, pin_b;
    logic [3:0] line_in;
    logic       drv_a2, drv_b2;

    t_adapter_out adapter_results_q[$];
    int unsigned  fail_count;
    logic         no_idle;

    t_stim_row directed_rows [0:24] = '{
        '{OP_READ,  ADDR_PORTA, 8'h00, 1'b0, 1'b1, '0},
        '{OP_READ,  ADDR_CTLB,  8'h00, 1'b0, 1'b1, '0},
        '{OP_WRITE, ADDR_PORTA, 8'hFF, 1'b0, 1'b1, '0},
        '{OP_WRITE, ADDR_CTLA,  8'h04, 1'b0, 1'b1, '0},
        '{OP_WRITE, ADDR_PORTA, 8'hFF, 1'b0, 1'b1,
          '{8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{OP_PINSA, ADDR_CTLB,  8'hA5, 1'b1, 1'b0, '0},
        '{OP_READ,  ADDR_PORTA, 8'hFF, 1'b1, 1'b0, '0},
        '{OP_WRITE, ADDR_CTLA,  8'h25, 1'b0, 1'b0, '0},
        '{OP_READ,  ADDR_PORTA, 8'h00, 1'b0, 1'b0, '0},
        '{OP_CA1,   ADDR_CTLB,  8'hFF, 1'b1, 1'b0, '0},
        '{OP_READ,  ADDR_CTLA,  8'h00, 1'b0, 1'b0, '0},
        '{OP_WRITE, ADDR_CTLA,  8'h2D, 1'b0, 1'b0, '0},
        '{OP_READ,  ADDR_PORTA, 8'h00, 1'b0, 1'b0, '0},
        '{OP_WRITE, ADDR_CTLA,  8'h37, 1'b0, 1'b0, '0},
        '{OP_CA2,   ADDR_PORTB, 8'h5A, 1'b1, 1'b0, '0},
        '{OP_WRITE, ADDR_CTLA,  8'h18, 1'b0, 1'b0, '0},
        '{OP_CA2,   ADDR_PORTA, 8'h00, 1'b0, 1'b0, '0},
        '{OP_WRITE, ADDR_PORTB, 8'h0F, 1'b0, 1'b0, '0},
        '{OP_WRITE, ADDR_CTLB,  8'h24, 1'b0, 1'b0, '0},
        '{OP_WRITE, ADDR_PORTB, 8'hF0, 1'b0, 1'b0, '0},
        '{OP_PINSB, ADDR_PORTA, 8'h3C, 1'b0, 1'b0, '0},
        '{OP_READ,  ADDR_PORTB, 8'h00, 1'b0, 1'b0, '0},
        '{OP_CB1,   ADDR_CTLA,  8'h81, 1'b1, 1'b0, '0},
        '{OP_CB2,   ADDR_CTLB,  8'h7E, 1'b1, 1'b0, '0},
        '{OP_READ,  ADDR_CTLB,  8'h00, 1'b0, 1'b0, '0}
    };

    peripheral_interface_adapter_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_reg_addr     (i_reg_addr),
        .i_data_byte    (i_data_byte),
        .i_line_level   (i_line_level),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_read_data    (o_read_data),
        .o_port_a_drive (o_port_a_drive),
        .o_port_b_drive (o_port_b_drive),
        .o_ca2_level    (o_ca2_level),
        .o_cb2_level    (o_cb2_level),
        .o_ca2_pulsed   (o_ca2_pulsed),
        .o_cb2_pulsed   (o_cb2_pulsed),
        .o_irq_a        (o_irq_a),
        .o_irq_b        (o_irq_b)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic side_irq(logic [7:0] cr);
        return (cr[CR_IRQ1] && cr[CR_L1EN]) ||
               (cr[CR_IRQ2] && !cr[CR_L2OUT] && cr[CR_L2LVL]);
    endfunction

    function automatic void edge_on_line1(inout logic [7:0] cr, inout logic drive,
                                          input logic old_lvl, input logic new_lvl);
        logic active;
        active = cr[CR_L1NEG] ? (old_lvl && !new_lvl) : (!old_lvl && new_lvl);
        if (active) begin
            cr[CR_IRQ1] = 1'b1;
            if (cr[CR_L2OUT] && !cr[CR_L2MAN] && !cr[CR_L2LVL]) begin
                drive = 1'b1;
            end
        end
    endfunction

    function automatic void edge_on_line2(inout logic [7:0] cr,
                                          input logic old_lvl, input logic new_lvl);
        logic active;
        active = cr[CR_L2MAN] ? (old_lvl && !new_lvl) : (!old_lvl && new_lvl);
        if (!cr[CR_L2OUT] && active) begin
            cr[CR_IRQ2] = 1'b1;
        end
    endfunction

    function automatic logic access_strobe(input logic [7:0] cr, inout logic drive);
        if (!cr[CR_L2OUT] || cr[CR_L2MAN]) begin
            return 1'b0;
        end
        drive = cr[CR_L2LVL];
        return 1'b1;
    endfunction

    function automatic void write_control(inout logic [7:0] cr, inout logic drive,
                                          input logic [7:0] value);
        cr = {cr[CR_IRQ1:CR_IRQ2], value[CR_L2OUT:0]};
        if (cr[CR_L2OUT] && cr[CR_L2MAN]) begin
            drive = cr[CR_L2LVL];
        end
    endfunction

    function automatic t_adapter_out adapter_step(logic [2:0] op, logic [1:0] addr,
                                                  logic [7:0] data, logic lvl);
        t_adapter_out r;
        logic         old_lvl;
        r = '0;
        case (op)
            OP_READ: begin
                case (addr)
                    ADDR_PORTA: begin
                        if (ctl_a[CR_DDR]) begin
                            r.read_data = pin_a;
                            ctl_a[CR_IRQ1] = 1'b0;
                            ctl_a[CR_IRQ2] = 1'b0;
                            r.ca2_pulsed = access_strobe(ctl_a, drv_a2);
                        end else begin
                            r.read_data = ddr_a;
                        end
                    end
                    ADDR_CTLA: begin
                        r.read_data = ctl_a;
                        if (ctl_a[CR_L2OUT]) r.read_data[CR_IRQ2] = 1'b0;
                    end
                    ADDR_PORTB: begin
                        if (ctl_b[CR_DDR]) begin
                            r.read_data = (orb & ddr_b) | (pin_b & ~ddr_b);
                            ctl_b[CR_IRQ1] = 1'b0;
                            ctl_b[CR_IRQ2] = 1'b0;
                        end else begin
                            r.read_data = ddr_b;
                        end
                    end
                    default: begin
                        r.read_data = ctl_b;
                        if (ctl_b[CR_L2OUT]) r.read_data[CR_IRQ2] = 1'b0;
                    end
                endcase
            end
            OP_WRITE: begin
                case (addr)
                    ADDR_PORTA: begin
                        if (ctl_a[CR_DDR]) ora = data;
                        else ddr_a = data;
                    end
                    ADDR_CTLA: write_control(ctl_a, drv_a2, data);
                    ADDR_PORTB: begin
                        if (ctl_b[CR_DDR]) begin
                            orb = data;
                            r.cb2_pulsed = access_strobe(ctl_b, drv_b2);
                        end else begin
                            ddr_b = data;
                        end
                    end
                    default: write_control(ctl_b, drv_b2, data);
                endcase
            end
            OP_PINSA: pin_a = data;
            OP_PINSB: pin_b = data;
            OP_CA1: begin
                old_lvl = line_in[0];
                line_in[0] = lvl;
                edge_on_line1(ctl_a, drv_a2, old_lvl, lvl);
            end
            OP_CA2: begin
                old_lvl = line_in[1];
                line_in[1] = lvl;
                edge_on_line2(ctl_a, old_lvl, lvl);
            end
            OP_CB1: begin
                old_lvl = line_in[2];
                line_in[2] = lvl;
                edge_on_line1(ctl_b, drv_b2, old_lvl, lvl);
            end
            default: begin
                old_lvl = line_in[3];
                line_in[3] = lvl;
                edge_on_line2(ctl_b, old_lvl, lvl);
            end
        endcase
        r.port_a_drive = ora & ddr_a;
        r.port_b_drive = orb & ddr_b;
        r.ca2_level = drv_a2;
        r.cb2_level = drv_b2;
        r.irq_a = side_irq(ctl_a);
        r.irq_b = side_irq(ctl_b);
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned exp_val,
                                        int unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    task automatic send_item(input logic [2:0] op, input logic [1:0] addr,
                             input logic [7:0] data, input logic lvl,
                             input logic typed, input t_adapter_out typed_res);
        int unsigned  gap;
        t_adapter_out predicted;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_reg_addr   <= addr;
        i_data_byte  <= data;
        i_line_level <= lvl;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = adapter_step(op, addr, data, lvl);
        adapter_results_q.push_back(typed ? typed_res : predicted);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (adapter_results_q.size() != 0);
    endtask

    initial begin
        int unsigned sel;
        logic [2:0]  op;
        logic [1:0]  addr;
        logic [7:0]  data;
        logic        lvl;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_opcode     = OP_READ;
        i_reg_addr   = ADDR_PORTA;
        i_data_byte  = 8'h00;
        i_line_level = 1'b0;
        i_out_ready  = 1'b0;
        fail_count   = 0;
        no_idle      = 1'b0;
        ctl_a = '0; ctl_b = '0; ddr_a = '0; ddr_b = '0; ora = '0; orb = '0;
        pin_a = PINS_RESET; pin_b = PINS_RESET;
        line_in = '0; drv_a2 = 1'b0; drv_b2 = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            send_item(directed_rows[k].op, directed_rows[k].addr, directed_rows[k].data,
                      directed_rows[k].lvl, directed_rows[k].typed, directed_rows[k].res);
        end
        drain_results();

        for (int n = 0; n < 1700; n++) begin
            no_idle = ((n / 150) % 4) == 3;
            if (n == 850) drain_results();
            sel  = $urandom_range(0, 99);
            addr = 2'($urandom_range(0, 3));
            data = 8'($urandom_range(0, 255));
            lvl  = 1'($urandom_range(0, 1));
            if (sel < 35) op = OP_READ;
            else if (sel < 65) op = OP_WRITE;
            else if (sel < 75) op = $urandom_range(0, 1) ? OP_PINSB : OP_PINSA;
            else op = OP_CA1 + 3'($urandom_range(0, 3));
            send_item(op, addr, data, lvl, 1'b0, '0);
        end

        drain_results();
        repeat (6) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        int unsigned  stall;
        t_adapter_out seen, want;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 17);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            seen = '{o_read_data, o_port_a_drive, o_port_b_drive, o_ca2_level, o_cb2_level,
                     o_ca2_pulsed, o_cb2_pulsed, o_irq_a, o_irq_b};
            if (adapter_results_q.size() == 0) begin
                $display("%0t: result with no item pending, actual %h", $time, seen);
                fail_count++;
            end else begin
                want = adapter_results_q.pop_front();
                check_field("read_data", want.read_data, seen.read_data);
                check_field("port_a_drive", want.port_a_drive, seen.port_a_drive);
                check_field("port_b_drive", want.port_b_drive, seen.port_b_drive);
                check_field("ca2_level", want.ca2_level, seen.ca2_level);
                check_field("cb2_level", want.cb2_level, seen.cb2_level);
                check_field("ca2_pulsed", want.ca2_pulsed, seen.ca2_pulsed);
                check_field("cb2_pulsed", want.cb2_pulsed, seen.cb2_pulsed);
                check_field("irq_a", want.irq_a, seen.irq_a);
                check_field("irq_b", want.irq_b, seen.irq_b);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ peripheral_interface_adapter_core.f @@
hw/rtl/pia_pkg.sv
hw/rtl/pia_side.sv
hw/rtl/peripheral_interface_adapter_core.sv
test/tb_peripheral_interface_adapter_core.sv
